[design/oahm_pkg.sv]
// Package for the open-addressed hash map: beat structs, status and command codes,
// and the hash multiplier constant.
// No dependencies.
package oahm_pkg;

  // Multiplicative hash constant (64-bit golden ratio)
  localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

  // Command codes
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADKEY = 2'd3;

  // Request beat
  typedef struct packed {
    logic               cmd;
    logic        [63:0] key;
    logic signed [63:0] value;
  } oahm_req_t;

  // Result beat
  typedef struct packed {
    logic        [1:0]  status;
    logic               found;
    logic signed [63:0] value_out;
    logic        [8:0]  entry_count;
  } oahm_rsp_t;

  // Memory control from the sequencer to the slot store
  typedef struct packed {
    logic rd;
    logic wr_key;
    logic wr_val;
  } oahm_mem_ctl_t;

endpackage

[design/open_address_hash_map.sv]
// Top level of the open-addressed hash map with linear probing.
// Depends on oahm_pkg, oahm_hash, oahm_store, oahm_ctrl.
//
//   channel  | ports             | beat taken when
//   ---------+-------------------+-------------------------------
//   request  | start, busy, req  | start high and busy low
//   result   | rsp_valid, rsp    | rsp_valid high (one cycle)
//
// An operation probes slot after slot, one key memory read and compare per
// slot; a zero key is answered straight from idle without a probe.
// The result beat is strobed in the first cycle with busy low again; the next
// request may be given in that same cycle.
// After reset the key memory is swept to empty, one slot per cycle, with busy
// high. The receiver cannot stall results.
module open_address_hash_map import oahm_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  oahm_req_t req,
  output logic      rsp_valid,
  output oahm_rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic [AW-1:0]      home_slot;
  oahm_mem_ctl_t      mem_ctl;
  logic [AW-1:0]      mem_addr;
  logic [63:0]        mem_wkey;
  logic signed [63:0] mem_wval;
  logic [63:0]        rd_key;
  logic signed [63:0] rd_val;

  // Home slot of the incoming key
  oahm_hash #(.AW(AW)) u_hash (
    .key_lo (req.key[AW-1:0]),
    .slot   (home_slot)
  );

  // Key and value memories
  oahm_store #(.AW(AW)) u_store (
    .clk    (clk),
    .ctl    (mem_ctl),
    .addr   (mem_addr),
    .wkey   (mem_wkey),
    .wval   (mem_wval),
    .rd_key (rd_key),
    .rd_val (rd_val)
  );

  // Sequencer
  oahm_ctrl #(.AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .home_slot (home_slot),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wkey  (mem_wkey),
    .mem_wval  (mem_wval),
    .rd_key    (rd_key),
    .rd_val    (rd_val),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

[design/oahm_hash.sv]
// Home slot computation: low address bits of key times the hash constant.
// Depends on oahm_pkg.
module oahm_hash import oahm_pkg::*; #(
  parameter int AW = 10
) (
  input  logic [AW-1:0] key_lo,
  output logic [AW-1:0] slot
);

  // Only the low AW bits of the product matter, so only low bits of the operands
  logic [AW-1:0]   mul_lo;
  logic [2*AW-1:0] prod;

  assign mul_lo = HASH_MUL[AW-1:0];
  assign prod   = key_lo * mul_lo;
  assign slot   = prod[AW-1:0];

endmodule

[design/oahm_store.sv]
// Slot store: key memory and value memory, one shared address, registered read.
// Depends on oahm_pkg.
module oahm_store import oahm_pkg::*; #(
  parameter int AW = 10
) (
  input  logic               clk,
  input  oahm_mem_ctl_t      ctl,
  input  logic [AW-1:0]      addr,
  input  logic [63:0]        wkey,
  input  logic signed [63:0] wval,
  output logic [63:0]        rd_key,
  output logic signed [63:0] rd_val
);

  localparam int DEPTH = 1 << AW;

  logic [63:0]        key_mem [DEPTH];
  logic signed [63:0] val_mem [DEPTH];

  // Key memory
  always_ff @(posedge clk) begin
    if (ctl.wr_key) begin
      key_mem[addr] <= wkey;
    end
    if (ctl.rd) begin
      rd_key <= key_mem[addr];
    end
  end

  // Value memory; no reset, read data only used from occupied slots
  always_ff @(posedge clk) begin
    if (ctl.wr_val) begin
      val_mem[addr] <= wval;
    end
    if (ctl.rd) begin
      rd_val <= val_mem[addr];
    end
  end

endmodule

[design/oahm_ctrl.sv]
// Sequencer: clearing pass, linear probe loop, put/get decision and result beat.
// Depends on oahm_pkg.
module oahm_ctrl import oahm_pkg::*; #(
  parameter int AW = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  oahm_req_t          req,
  output logic               busy,
  input  logic [AW-1:0]      home_slot,
  output oahm_mem_ctl_t      mem_ctl,
  output logic [AW-1:0]      mem_addr,
  output logic [63:0]        mem_wkey,
  output logic signed [63:0] mem_wval,
  input  logic [63:0]        rd_key,
  input  logic signed [63:0] rd_val,
  output logic               rsp_valid,
  output oahm_rsp_t          rsp
);

  localparam int CW = AW - 1;
  localparam logic [CW-1:0] LIMIT = CW'((1 << AW) / 2 - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PROBE = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  state_t             state;
  logic [AW-1:0]      clr_idx;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      steps;
  logic               cmd_r;
  logic [63:0]        key_r;
  logic signed [63:0] value_r;

  logic               accept;
  logic               hit;
  logic               ended;
  logic               finish;
  logic               at_limit;
  oahm_rsp_t          rsp_next;
  oahm_rsp_t          rsp_bad;
  logic [CW+8:0]      cnt_ext;
  logic [CW+8:0]      cnt_cur_ext;

  assign busy   = (state != S_IDLE);
  assign accept = (state == S_IDLE) && start;

  // Probe outcome for the slot just read
  assign hit      = (rd_key == key_r);
  assign ended    = (rd_key == 64'd0) || hit;
  assign finish   = ended || (steps == {AW{1'b1}});
  assign at_limit = (count == LIMIT);

  // Memory port
  always_comb begin
    mem_addr   = (state == S_CLEAR) ? clr_idx : pos;
    mem_wkey   = (state == S_CLEAR) ? 64'd0 : key_r;
    mem_wval   = value_r;
  end

  // Put/get decision, memory strobes and result payload
  always_comb begin
    count_next         = count;
    mem_ctl.rd         = (state == S_PROBE);
    mem_ctl.wr_key     = (state == S_CLEAR);
    mem_ctl.wr_val     = 1'b0;
    rsp_next.status    = ST_OK;
    rsp_next.found     = 1'b0;
    rsp_next.value_out = 64'sd0;
    if (state == S_CHECK) begin
      if (cmd_r == CMD_GET) begin
        if (hit) begin
          rsp_next.found     = 1'b1;
          rsp_next.value_out = rd_val;
        end else begin
          rsp_next.status = ST_MISS;
        end
      end else if (hit) begin
        rsp_next.found = 1'b1;
        mem_ctl.wr_val = 1'b1;
      end else if (!ended || at_limit) begin
        rsp_next.status = ST_FULL;
      end else if (finish) begin
        mem_ctl.wr_key = 1'b1;
        mem_ctl.wr_val = 1'b1;
        count_next     = count + 1'b1;
      end
    end
    cnt_ext              = {9'd0, count_next};
    rsp_next.entry_count = cnt_ext[8:0];
  end

  // Bad key answer, taken straight at accept
  always_comb begin
    cnt_cur_ext         = {9'd0, count};
    rsp_bad.status      = ST_BADKEY;
    rsp_bad.found       = 1'b0;
    rsp_bad.value_out   = 64'sd0;
    rsp_bad.entry_count = cnt_cur_ext[8:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req.key == 64'd0) begin
              rsp_valid <= 1'b1;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (finish) begin
            rsp_valid <= 1'b1;
            count     <= count_next;
            state     <= S_IDLE;
          end else begin
            state <= S_PROBE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Payload: latched request, probe position and result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= req.cmd;
      key_r   <= req.key;
      value_r <= req.value;
      pos     <= home_slot;
      steps   <= '0;
      rsp     <= rsp_bad;
    end else if (state == S_CHECK) begin
      if (finish) begin
        rsp <= rsp_next;
      end else begin
        pos   <= pos + 1'b1;
        steps <= steps + 1'b1;
      end
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for open_address_hash_map: puts and gets against a predictor
// of the slot table. Depends on oahm_pkg and the open_address_hash_map RTL.
module testbench;
  import oahm_pkg::*;

  localparam int CAP           = 1024;
  localparam int SLOT_BITS     = $clog2(CAP);
  localparam int LIMIT_ENTRIES = CAP / 2 - 1;
  localparam int TOTAL_BEATS   = 1550;
  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  oahm_req_t req;
  logic      rsp_valid;
  oahm_rsp_t rsp;

  // Predicted slot table
  logic [63:0] slot_key [CAP];
  logic [63:0] slot_val [CAP];
  int unsigned map_entries;
  logic [63:0] stored_keys [$];

  // Answers waiting for their result beat
  oahm_rsp_t   expected_rsp [$];
  oahm_rsp_t   want_rsp;

  int unsigned hot_slots [4];
  int          burst_left;
  int          beats_sent;
  int          results_seen;
  int          mismatch_count;
  int          put_count;
  int          get_count;
  int          status_count [4];
  int          longest_probe;

  open_address_hash_map #(.CAPACITY(CAP)) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, sized for every beat walking the whole table
  initial begin
    #200_000_000;
    $display("Timeout: %0d of %0d results still outstanding", expected_rsp.size(), beats_sent);
    $display("Mismatches found");
    $finish;
  end

  // Applies one operation to the predicted table and returns its answer
  function automatic oahm_rsp_t predict_map_op(input oahm_req_t beat);
    oahm_rsp_t            ans;
    logic [63:0]          prod;
    logic [SLOT_BITS-1:0] pos;
    int                   probes;
    bit                   ended;
    bit                   hit;
    ans   = '0;
    ended = 1'b0;
    if (beat.cmd == CMD_PUT) put_count++;
    else get_count++;
    if (beat.key == '0) begin
      ans.status = ST_BADKEY;
    end else begin
      prod = beat.key * HASH_MUL;
      pos  = prod[SLOT_BITS-1:0];
      for (probes = 0; probes < CAP; probes++) begin
        if (slot_key[pos] == '0 || slot_key[pos] == beat.key) begin
          ended = 1'b1;
          break;
        end
        pos = pos + 1'b1;
      end
      if (probes + 1 > longest_probe) longest_probe = probes + 1;
      hit = ended && slot_key[pos] == beat.key;
      if (beat.cmd == CMD_GET) begin
        if (hit) begin
          ans.found     = 1'b1;
          ans.value_out = slot_val[pos];
        end else begin
          ans.status = ST_MISS;
        end
      end else if (hit) begin
        ans.found     = 1'b1;
        slot_val[pos] = beat.value;
      end else if (!ended || (map_entries + 1) * 2 >= CAP) begin
        ans.status = ST_FULL;
      end else begin
        slot_key[pos] = beat.key;
        slot_val[pos] = beat.value;
        map_entries++;
        stored_keys.push_back(beat.key);
      end
    end
    ans.entry_count = map_entries[8:0];
    status_count[ans.status]++;
    return ans;
  endfunction

  function automatic logic [63:0] fresh_key();
    return {$urandom, $urandom};
  endfunction

  // Random key whose hash lands on the given home slot
  function automatic logic [63:0] key_homed_at(input int unsigned slot);
    logic [63:0] k;
    logic [63:0] prod;
    k = fresh_key();
    for (int j = 0; j < CAP; j++) begin
      k[SLOT_BITS-1:0] = SLOT_BITS'(j);
      prod = k * HASH_MUL;
      if (prod[SLOT_BITS-1:0] == SLOT_BITS'(slot)) break;
    end
    return k;
  endfunction

  function automatic logic [63:0] live_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  function automatic logic [63:0] hot_key();
    return key_homed_at(hot_slots[2'($urandom_range(0, 3))]);
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sends one request beat; entered and left at a falling edge. Start stays high
  // on exit so a following beat goes out back to back.
  task automatic send_beat(input logic op, input logic [63:0] k, input logic [63:0] v);
    oahm_req_t beat;
    int        gap;
    beat.cmd   = op;
    beat.key   = k;
    beat.value = v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    req   <= beat;
    do @(posedge clk); while (busy !== 1'b0);
    expected_rsp.push_back(predict_map_op(beat));
    beats_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every answer is back
  task automatic drain_results();
    start <= 1'b0;
    wait (expected_rsp.size() == 0);
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input oahm_rsp_t want, input oahm_rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t result %0d %s: expected st=%0d fnd=%0b val=%0d cnt=%0d,",
                " got st=%0d fnd=%0b val=%0d cnt=%0d"},
               $realtime, results_seen, what, want.status, want.found, want.value_out,
               want.entry_count, got.status, got.found, got.value_out, got.entry_count);
  endtask

  // Result checker: every strobed beat is matched against the oldest answer
  always @(posedge clk) begin
    if (!rst && rsp_valid !== 1'b0) begin
      results_seen++;
      if (expected_rsp.size() == 0) begin
        note_mismatch("unexpected", '0, rsp);
      end else begin
        want_rsp = expected_rsp.pop_front();
        if (rsp !== want_rsp) note_mismatch("wrong", want_rsp, rsp);
      end
    end
  end

  // Field extremes, both commands, zero key, update, and a cluster that wraps
  task automatic test_directed();
    logic [63:0] wrap_key [3];
    for (int i = 0; i < 3; i++) wrap_key[2'(i)] = key_homed_at(CAP - 1);
    send_beat(CMD_PUT, '0, VAL_MAX);
    send_beat(CMD_GET, '0, '1);
    send_beat(CMD_GET, '1, '0);
    send_beat(CMD_PUT, '1, VAL_MAX);
    send_beat(CMD_GET, '1, '0);
    send_beat(CMD_PUT, '1, VAL_MIN);
    send_beat(CMD_GET, '1, VAL_MAX);
    send_beat(CMD_PUT, 64'd1, '1);
    send_beat(CMD_GET, 64'd1, '0);
    send_beat(CMD_PUT, VAL_MIN, '0);
    send_beat(CMD_GET, VAL_MIN, '1);
    // three keys homed on the last slot spill over to the front
    for (int i = 0; i < 3; i++) send_beat(CMD_PUT, wrap_key[2'(i)], rand_value());
    for (int i = 0; i < 3; i++) send_beat(CMD_GET, wrap_key[2'(i)], '0);
    send_beat(CMD_GET, key_homed_at(CAP - 1), '0);
    send_beat(CMD_PUT, wrap_key[2], VAL_MAX);
    send_beat(CMD_GET, wrap_key[2], '0);
    drain_results();
  endtask

  // Mixed traffic while the table fills up to its limit
  task automatic test_fill();
    int  r;
    bit  paused;
    paused = 1'b0;
    while (map_entries < LIMIT_ENTRIES) begin
      r = $urandom_range(0, 99);
      if (r < 45 || r >= 98)  send_beat(CMD_PUT, fresh_key(), rand_value());
      else if (r < 60)        send_beat(CMD_PUT, hot_key(), rand_value());
      else if (r < 70)        send_beat(CMD_PUT, live_key(), rand_value());
      else if (r < 82)        send_beat(CMD_GET, live_key(), rand_value());
      else if (r < 90)        send_beat(CMD_GET, fresh_key(), rand_value());
      else if (r < 95)        send_beat(CMD_GET, hot_key(), rand_value());
      else                    send_beat(1'($urandom), '0, rand_value());
      if (!paused && map_entries >= LIMIT_ENTRIES / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end
    drain_results();
  endtask

  // Table at its limit: new keys refused, updates and lookups still served
  task automatic test_at_limit();
    int r;
    int remaining;
    remaining = (TOTAL_BEATS - beats_sent > 200) ? TOTAL_BEATS - beats_sent : 200;
    for (int i = 0; i < remaining; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25)      send_beat(CMD_PUT, fresh_key(), rand_value());
      else if (r < 35) send_beat(CMD_PUT, hot_key(), rand_value());
      else if (r < 55) send_beat(CMD_PUT, live_key(), rand_value());
      else if (r < 75) send_beat(CMD_GET, live_key(), rand_value());
      else if (r < 90) send_beat(CMD_GET, fresh_key(), rand_value());
      else if (r < 95) send_beat(CMD_GET, hot_key(), rand_value());
      else             send_beat(1'($urandom), '0, rand_value());
      if (i == remaining / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    slot_key = '{default: '0};
    slot_val = '{default: '0};
    map_entries = 0;
    hot_slots   = '{CAP - 3, 2, CAP / 3, CAP / 2 + 7};
    burst_left  = 0;
    beats_sent  = 0;
    results_seen   = 0;
    mismatch_count = 0;
    put_count   = 0;
    get_count   = 0;
    status_count = '{0, 0, 0, 0};
    longest_probe = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill();
    test_at_limit();

    // late or extra beats would show up in this window
    repeat (2 * CAP + 16) @(posedge clk);
    $display("%0d beats (%0d put, %0d get): %0d ok, %0d miss, %0d full, %0d zero key",
             beats_sent, put_count, get_count, status_count[ST_OK], status_count[ST_MISS],
             status_count[ST_FULL], status_count[ST_BADKEY]);
    $display("Table reached %0d keys; longest probe walked %0d slots",
             map_entries, longest_probe);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d result beats disagreed with the prediction", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
